// File: rtl/ipid_pkg.sv
// Shared types and constants of the incremental PID base-time block.
package ipid_pkg;

	// Field widths fixed by the interface
	localparam int GAIN_W      = 16;
	localparam int LEVEL_W     = 9;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// Drive range and scaling
	localparam int DRIVE_MAX   = 10000;
	localparam int LEVEL_MAX   = 500;
	// Integer bits of the clamped drive (10000 < 2**14)
	localparam int DRIVE_INT_W = 14;
	// Drive integer divided by four, 0..2500
	localparam int QUARTER_W   = DRIVE_INT_W - 2;
	// Divide by five: (x * 13108) >> 16 is exact for x below 3276
	localparam int DIV5_RECIP  = 13108;
	localparam int DIV5_W      = 14;
	localparam int DIV5_SHIFT  = 16;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_NOW         = 3'd0,
		CFG_GAIN_LAST        = 3'd1,
		CFG_GAIN_BEFORE_LAST = 3'd2,
		CFG_BASE_LOW_LIMIT   = 3'd3,
		CFG_BASE_HIGH_LIMIT  = 3'd4
	} cfg_idx_t;

	// Configuration register set
	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_now;
		logic signed [GAIN_W-1:0] gain_last;
		logic signed [GAIN_W-1:0] gain_before_last;
		logic [LEVEL_W-1:0]       base_low_limit;
		logic [LEVEL_W-1:0]       base_high_limit;
	} cfg_t;

	// Reset values of the configuration registers
	localparam logic signed [GAIN_W-1:0] GAIN_NOW_RST         = 16'sd819;
	localparam logic signed [GAIN_W-1:0] GAIN_LAST_RST        = 16'sd82;
	localparam logic signed [GAIN_W-1:0] GAIN_BEFORE_LAST_RST = 16'sd41;
	localparam logic [LEVEL_W-1:0]       BASE_LOW_LIMIT_RST   = 9'd20;
	localparam logic [LEVEL_W-1:0]       BASE_HIGH_LIMIT_RST  = 9'd500;

endpackage

// File: rtl/ipid_cfg_regs.sv
// Configuration register file of the incremental PID base-time block.
module ipid_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [ipid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ipid_pkg::CFG_DATA_W-1:0]   cfg_data,
	output ipid_pkg::cfg_t                    cfg
);

	ipid_pkg::cfg_t cfg_q;

	// Register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_now         <= ipid_pkg::GAIN_NOW_RST;
			cfg_q.gain_last        <= ipid_pkg::GAIN_LAST_RST;
			cfg_q.gain_before_last <= ipid_pkg::GAIN_BEFORE_LAST_RST;
			cfg_q.base_low_limit   <= ipid_pkg::BASE_LOW_LIMIT_RST;
			cfg_q.base_high_limit  <= ipid_pkg::BASE_HIGH_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (ipid_pkg::cfg_idx_t'(cfg_index))
				ipid_pkg::CFG_GAIN_NOW: begin
					cfg_q.gain_now <= $signed(cfg_data[ipid_pkg::GAIN_W-1:0]);
				end
				ipid_pkg::CFG_GAIN_LAST: begin
					cfg_q.gain_last <= $signed(cfg_data[ipid_pkg::GAIN_W-1:0]);
				end
				ipid_pkg::CFG_GAIN_BEFORE_LAST: begin
					cfg_q.gain_before_last <= $signed(cfg_data[ipid_pkg::GAIN_W-1:0]);
				end
				ipid_pkg::CFG_BASE_LOW_LIMIT: begin
					cfg_q.base_low_limit <= cfg_data[ipid_pkg::LEVEL_W-1:0];
				end
				ipid_pkg::CFG_BASE_HIGH_LIMIT: begin
					cfg_q.base_high_limit <= cfg_data[ipid_pkg::LEVEL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/ipid_drive.sv
// Error history, gain products and clamped drive accumulator (stages 1 to 3).
module ipid_drive #(
	parameter int SAMPLE_BITS    = 12,
	parameter int GAIN_FRAC_BITS = 12,
	localparam int AW            = ipid_pkg::DRIVE_INT_W + GAIN_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ipid_pkg::cfg_t         cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] target_level,
	input  logic [SAMPLE_BITS-1:0] measured_level,
	output logic                   drive_valid,
	input  logic                   drive_ready,
	output logic [AW-1:0]          drive_value
);

	localparam int EW = SAMPLE_BITS + 1;
	localparam int PW = ipid_pkg::GAIN_W + EW;
	localparam int SW = ((PW > AW + 1) ? PW : AW + 1) + 2;
	localparam logic signed [SW-1:0] TOP_S =
		SW'(longint'(ipid_pkg::DRIVE_MAX) <<< GAIN_FRAC_BITS);
	localparam logic [AW-1:0] TOP_U = AW'(longint'(ipid_pkg::DRIVE_MAX) <<< GAIN_FRAC_BITS);

	logic signed [EW-1:0] err;
	logic signed [EW-1:0] err_s1, e1_s1, e2_s1;
	logic signed [EW-1:0] error_last_q, error_before_last_q;
	logic signed [PW-1:0] prod0, prod1, prod2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2;
	logic signed [SW-1:0] sum;
	logic [AW-1:0]        clamped;
	logic [AW-1:0]        drive_accum_s3;
	logic                 v1_q, v2_q, v3_q;
	logic                 rdy1, rdy2, rdy3;

	// Stage readiness: a stage loads when empty or when its successor loads
	assign rdy3     = !v3_q || drive_ready;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign in_ready = rdy1;

	// Error is measured minus setpoint
	assign err = $signed({1'b0, measured_level}) - $signed({1'b0, target_level});

	// Stage 1: current error and the two earlier ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q                <= 1'b0;
			error_last_q        <= '0;
			error_before_last_q <= '0;
		end else if (rdy1) begin
			v1_q <= in_valid;
			if (in_valid) begin
				error_last_q        <= err;
				error_before_last_q <= error_last_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			err_s1 <= err;
			e1_s1  <= error_last_q;
			e2_s1  <= error_before_last_q;
		end
	end

	// Stage 2: three gain products, each registered
	assign prod0 = PW'(cfg.gain_now) * PW'(err_s1);
	assign prod1 = PW'(cfg.gain_last) * PW'(e1_s1);
	assign prod2 = PW'(cfg.gain_before_last) * PW'(e2_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (rdy2) begin
			v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v1_q) begin
			p0_s2 <= prod0;
			p1_s2 <= prod1;
			p2_s2 <= prod2;
		end
	end

	// Stage 3: accumulate and clamp to 0..DRIVE_MAX
	assign sum = $signed(SW'({1'b0, drive_accum_s3})) + SW'(p0_s2) + SW'(p1_s2) + SW'(p2_s2);

	always_comb begin
		priority if (sum <= 0) begin
			clamped = '0;
		end else if (sum > TOP_S) begin
			clamped = TOP_U;
		end else begin
			clamped = sum[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q           <= 1'b0;
			drive_accum_s3 <= '0;
		end else if (rdy3) begin
			v3_q <= v2_q;
			if (v2_q) begin
				drive_accum_s3 <= clamped;
			end
		end
	end

	assign drive_valid = v3_q;
	assign drive_value = drive_accum_s3;

	// Accumulator never leaves the clamp range
	a_accum_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive_accum_s3 <= TOP_U)
		else $error("drive accumulator above upper clamp");

endmodule

// File: rtl/ipid_base.sv
// Drive scaling by twenty, window check and base-time output register (stage 4).
module ipid_base #(
	parameter int GAIN_FRAC_BITS = 12,
	localparam int AW            = ipid_pkg::DRIVE_INT_W + GAIN_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ipid_pkg::cfg_t               cfg,
	input  logic                         drive_valid,
	output logic                         drive_ready,
	input  logic [AW-1:0]                drive_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ipid_pkg::LEVEL_W-1:0] drive_level,
	output logic [ipid_pkg::LEVEL_W-1:0] base_time,
	output logic                         base_changed
);

	localparam int QW = ipid_pkg::QUARTER_W;
	localparam int MW = QW + ipid_pkg::DIV5_W;
	localparam logic [ipid_pkg::DIV5_W-1:0] RECIP = ipid_pkg::DIV5_W'(ipid_pkg::DIV5_RECIP);

	logic [QW-1:0]                quarter;
	logic [MW-1:0]                scaled;
	logic [ipid_pkg::LEVEL_W-1:0] level;
	logic                         in_window;
	logic                         v4_q;
	logic [ipid_pkg::LEVEL_W-1:0] level_s4;
	logic                         changed_s4;
	logic [ipid_pkg::LEVEL_W-1:0] base_hold_q;

	assign drive_ready = !v4_q || out_ready;

	// floor(drive / (20 << frac)) = floor((drive >> (frac + 2)) / 5)
	assign quarter   = drive_value[AW-1:GAIN_FRAC_BITS+2];
	assign scaled    = MW'(quarter) * MW'(RECIP);
	assign level     = scaled[ipid_pkg::DIV5_SHIFT +: ipid_pkg::LEVEL_W];
	assign in_window = (level >= cfg.base_low_limit) && (level <= cfg.base_high_limit);

	// Output register and held base time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_q        <= 1'b0;
			base_hold_q <= '0;
		end else if (drive_ready) begin
			v4_q <= drive_valid;
			if (drive_valid && in_window) begin
				base_hold_q <= level;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drive_ready && drive_valid) begin
			level_s4   <= level;
			changed_s4 <= in_window;
		end
	end

	assign out_valid    = v4_q;
	assign drive_level  = level_s4;
	assign base_time    = base_hold_q;
	assign base_changed = changed_s4;

endmodule

// File: rtl/incremental_pid_base_time_unit.sv
// The error history, the gain products, the drive accumulator and the output register
// form a four-stage pipeline that takes one transaction per cycle while out_ready is high;
// a low out_ready holds the full stages back.
// The accumulator loop closes within stage 3.
// Reset clears the error history, drive accumulator and base time, and loads
// the default gains and window limits.
module incremental_pid_base_time_unit #(
	parameter int SAMPLE_BITS    = 12,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [ipid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipid_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [SAMPLE_BITS-1:0]          target_level,
	input  logic [SAMPLE_BITS-1:0]          measured_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ipid_pkg::LEVEL_W-1:0]    drive_level,
	output logic [ipid_pkg::LEVEL_W-1:0]    base_time,
	output logic                            base_changed
);

	localparam int AW = ipid_pkg::DRIVE_INT_W + GAIN_FRAC_BITS;

	ipid_pkg::cfg_t cfg;
	logic           drive_valid;
	logic           drive_ready;
	logic [AW-1:0]  drive_value;

	// Configuration registers
	ipid_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Error history, products and accumulator
	ipid_drive #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_drive (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.target_level   (target_level),
		.measured_level (measured_level),
		.drive_valid    (drive_valid),
		.drive_ready    (drive_ready),
		.drive_value    (drive_value)
	);

	// Scaling, window and output
	ipid_base #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_base (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.drive_valid  (drive_valid),
		.drive_ready  (drive_ready),
		.drive_value  (drive_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.drive_level  (drive_level),
		.base_time    (base_time),
		.base_changed (base_changed)
	);

	// Scaled drive stays within its range
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_level <= ipid_pkg::LEVEL_W'(ipid_pkg::LEVEL_MAX)))
		else $error("drive level above maximum");

	// A taken level becomes the base time
	a_taken_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && base_changed) |-> (base_time == drive_level))
		else $error("base time differs from taken drive level");

	// An untaken level lies outside the window
	a_untaken_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !base_changed) |->
		((drive_level < cfg.base_low_limit) || (drive_level > cfg.base_high_limit)))
		else $error("level inside window was not taken");

endmodule
